@@ rtl/ptda_pkg.sv @@
// Package for the per-tag distance averager: sizes, function codes, beat structs.
// No dependencies.
package ptda_pkg;
  localparam int TAG_SLOTS  = 16;
  localparam int ANCHORS    = 4;
  localparam int COUNT_BITS = 16;
  localparam int DIST_BITS  = 20;
  localparam int AVG_BITS   = 19;
  localparam int SUM_BITS   = AVG_BITS + COUNT_BITS;
  localparam int SLOT_BITS  = (TAG_SLOTS > 1) ? $clog2(TAG_SLOTS) : 1;
  localparam int SCNT_BITS  = $clog2(TAG_SLOTS + 1);
  localparam int DIV_STEPS  = SUM_BITS;
  localparam int STEP_BITS  = $clog2(DIV_STEPS + 1);

  localparam logic [1:0] FUNC_INJECT   = 2'd0;
  localparam logic [1:0] FUNC_READ_ONE = 2'd1;
  localparam logic [1:0] FUNC_READ_ALL = 2'd2;

  localparam logic [1:0] REG_FIRST_TAG   = 2'd0;
  localparam logic [1:0] REG_MIN_ANCHORS = 2'd1;

  typedef struct packed {
    logic [1:0]                  func;
    logic [15:0]                 tag_id;
    logic signed [DIST_BITS-1:0] dist_a0;
    logic signed [DIST_BITS-1:0] dist_a1;
    logic signed [DIST_BITS-1:0] dist_a2;
    logic signed [DIST_BITS-1:0] dist_a3;
  } in_beat_t;

  typedef struct packed {
    logic                found;
    logic [15:0]         out_tag;
    logic [AVG_BITS-1:0] avg_a0;
    logic [AVG_BITS-1:0] avg_a1;
    logic [AVG_BITS-1:0] avg_a2;
    logic [AVG_BITS-1:0] avg_a3;
    logic                last;
  } out_beat_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } lane_ctl_t;
endpackage

@@ rtl/ptda_div_lane.sv @@
// One anchor lane: restoring divider, one quotient bit per cycle.
// Depends on ptda_pkg.
module ptda_div_lane (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ptda_pkg::SUM_BITS-1:0]   sum,
  input  logic [ptda_pkg::COUNT_BITS-1:0] count,
  output logic                       busy,
  output logic [ptda_pkg::AVG_BITS-1:0]   quot
);
  import ptda_pkg::*;

  logic [SUM_BITS-1:0]   q;
  logic [COUNT_BITS:0]   rem;
  logic [COUNT_BITS-1:0] dvs;
  logic [STEP_BITS-1:0]  step;
  logic [COUNT_BITS:0]   trial;
  logic [COUNT_BITS:0]   rem_sh;

  assign rem_sh = {rem[COUNT_BITS-1:0], q[SUM_BITS-1]};
  assign trial  = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= STEP_BITS'(DIV_STEPS);
    end else if (busy) begin
      step <= step - 1'b1;
      if (step == STEP_BITS'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= sum;
      rem <= '0;
      dvs <= count;
    end else if (busy) begin
      if (!trial[COUNT_BITS]) begin
        rem <= trial;
        q   <= {q[SUM_BITS-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        q   <= {q[SUM_BITS-2:0], 1'b0};
      end
    end
  end

  assign quot = (dvs == '0) ? '0 : q[AVG_BITS-1:0];
endmodule

@@ rtl/per_tag_distance_averager.sv @@
// Top level of the per-tag distance averager: slot table, sequencer, four divider lanes.
// Depends on ptda_pkg and ptda_div_lane.
//
// One input beat is handled at a time; in_ready is high only while the sequencer is idle.
// An inject goes through accept, row fetch and write back before in_ready rises again.
// A read-one hit goes through accept, row fetch, lane load, the four parallel bit-serial
// dividers (35 quotient bits, then the done check) and the result beat. A read-one miss
// goes from accept straight to the result beat for an out-of-range tag and fetches the
// row first for an inactive slot. A read-all fetches each slot in turn, skips an inactive
// one, divides an active one and skips it when short of min_anchors, else emits it; the
// closing beat comes last. A result waits in the single output register until taken,
// so output stalls hold up the sequencer. Per-slot valid bits reset-clear the slot table.
module per_tag_distance_averager (
  input  logic                clk,
  input  logic                rst,
  input  ptda_pkg::in_beat_t  in_data,
  input  logic                in_valid,
  output logic                in_ready,
  output ptda_pkg::out_beat_t out_data,
  output logic                out_valid,
  input  logic                out_ready,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import ptda_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FETCH = 3'd1;
  localparam logic [2:0] ST_INJ   = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;
  localparam logic [2:0] ST_SCAN  = 3'd5;
  localparam logic [2:0] ST_TERM  = 3'd6;
  localparam logic [2:0] ST_START = 3'd7;

  localparam int ROW_BITS = ANCHORS * (SUM_BITS + COUNT_BITS);

  logic [15:0] first_tag;
  logic [2:0]  min_anchors;
  logic [2:0]  state;
  in_beat_t    cur;
  logic                 miss;
  logic [SLOT_BITS-1:0] slot;
  logic [SCNT_BITS-1:0] scan;
  logic                 all_mode;
  logic [TAG_SLOTS-1:0] active;
  logic [TAG_SLOTS-1:0] row_ok;
  logic [ROW_BITS-1:0]  mem [TAG_SLOTS];
  logic [ROW_BITS-1:0]  rd_row;
  logic [ROW_BITS-1:0]  wr_row;
  logic                 wr_en;
  logic [SUM_BITS-1:0]   sums [ANCHORS];
  logic [COUNT_BITS-1:0] cnts [ANCHORS];
  logic [AVG_BITS-1:0]   quot [ANCHORS];
  logic [ANCHORS-1:0]    lane_busy;
  lane_ctl_t             ctl;
  logic [2:0]            with_data;
  logic [16:0]           off;
  logic                  in_range;
  logic [SLOT_BITS-1:0]  in_slot;

  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[2])
      REG_FIRST_TAG[0]:   prdata = {16'd0, first_tag};
      default:            prdata = {29'd0, min_anchors};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_tag   <= '0;
      min_anchors <= 3'd3;
    end else if (psel && penable && pwrite) begin
      if (paddr[2:2] == REG_FIRST_TAG[0:0]) first_tag <= pwdata[15:0];
      else if (paddr[2:2] == REG_MIN_ANCHORS[0:0]) min_anchors <= pwdata[2:0];
    end
  end

  assign off      = {1'b0, in_data.tag_id} - {1'b0, first_tag};
  assign in_range = !off[16] && (off[15:0] < 16'(TAG_SLOTS));
  assign in_slot  = off[SLOT_BITS-1:0];
  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    rd_row <= mem[slot];
    if (wr_en) mem[slot] <= wr_row;
  end

  always_comb begin
    for (int a = 0; a < ANCHORS; a++) begin
      sums[a] = row_ok[slot] ? rd_row[a*(SUM_BITS+COUNT_BITS)+COUNT_BITS +: SUM_BITS] : '0;
      cnts[a] = row_ok[slot] ? rd_row[a*(SUM_BITS+COUNT_BITS) +: COUNT_BITS] : '0;
    end
  end

  always_comb begin
    logic [DIST_BITS-1:0] d;
    logic [ANCHORS*DIST_BITS-1:0] ds;
    ds = {cur.dist_a3, cur.dist_a2, cur.dist_a1, cur.dist_a0};
    wr_row = '0;
    for (int a = 0; a < ANCHORS; a++) begin
      d = ds[a*DIST_BITS +: DIST_BITS];
      if (state == ST_INJ && d != '0 && !d[DIST_BITS-1] && cnts[a] != '1) begin
        wr_row[a*(SUM_BITS+COUNT_BITS)+COUNT_BITS +: SUM_BITS] =
          sums[a] + SUM_BITS'(d);
        wr_row[a*(SUM_BITS+COUNT_BITS) +: COUNT_BITS] = cnts[a] + 1'b1;
      end else if (state == ST_INJ) begin
        wr_row[a*(SUM_BITS+COUNT_BITS)+COUNT_BITS +: SUM_BITS] = sums[a];
        wr_row[a*(SUM_BITS+COUNT_BITS) +: COUNT_BITS] = cnts[a];
      end
    end
  end
  assign wr_en = (state == ST_INJ);

  // rd_row holds the addressed row in the cycle after the fetch
  assign ctl.start = (state == ST_START);
  assign ctl.busy  = |lane_busy;
  assign ctl.done  = (state == ST_DIV) && !ctl.busy;

  for (genvar g = 0; g < ANCHORS; g++) begin : g_lane
    ptda_div_lane u_lane (
      .clk   (clk),
      .rst   (rst),
      .start (ctl.start && cur.func != FUNC_INJECT),
      .sum   (sums[g]),
      .count (cnts[g]),
      .busy  (lane_busy[g]),
      .quot  (quot[g])
    );
  end

  logic [ANCHORS-1:0] has;
  always_ff @(posedge clk) begin
    if (ctl.start && cur.func != FUNC_INJECT)
      for (int a = 0; a < ANCHORS; a++) has[a] <= (cnts[a] != '0);
  end
  assign with_data = 3'(has[0]) + 3'(has[1]) + 3'(has[2]) + 3'(has[3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      active    <= '0;
      row_ok    <= '0;
      all_mode  <= 1'b0;
      scan      <= '0;
    end else begin
      if (out_valid && out_ready && state != ST_EMIT && state != ST_TERM)
        out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: if (in_valid) begin
          cur  <= in_data;
          miss <= (in_data.func == FUNC_READ_ONE) && !in_range;
          unique case (in_data.func)
            FUNC_INJECT: if (in_range) begin
              slot <= in_slot; state <= ST_FETCH; all_mode <= 1'b0;
            end
            FUNC_READ_ONE: if (in_range) begin
              slot <= in_slot; state <= ST_FETCH; all_mode <= 1'b0;
            end else begin
              state <= ST_EMIT; all_mode <= 1'b0; slot <= '0;
            end
            FUNC_READ_ALL: begin
              slot <= '0; scan <= '0; all_mode <= 1'b1; state <= ST_SCAN;
            end
            default: ;
          endcase
        end
        ST_SCAN: begin
          if (scan == SCNT_BITS'(TAG_SLOTS)) state <= ST_TERM;
          else begin
            slot  <= scan[SLOT_BITS-1:0];
            state <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          if (cur.func == FUNC_INJECT) state <= ST_INJ;
          else if (active[slot]) begin
            state <= ST_START;
          end else if (all_mode) begin
            scan <= scan + 1'b1; state <= ST_SCAN;
          end else begin
            miss <= 1'b1; state <= ST_EMIT;
          end
        end
        ST_START: begin
          active[slot] <= 1'b0;
          row_ok[slot] <= 1'b0;
          state        <= ST_DIV;
        end
        ST_INJ: begin
          row_ok[slot] <= 1'b1;
          active[slot] <= active[slot] |
            (cur.dist_a0 > 0 || cur.dist_a1 > 0 || cur.dist_a2 > 0 || cur.dist_a3 > 0);
          state <= ST_IDLE;
        end
        ST_DIV: if (ctl.done) begin
          if (all_mode && !({1'b0, with_data} >= {1'b0, min_anchors})) begin
            scan <= scan + 1'b1; state <= ST_SCAN;
          end else state <= ST_EMIT;
        end
        ST_EMIT: if (!out_valid || out_ready) begin
          out_valid        <= 1'b1;
          out_data.found   <= !miss;
          out_data.out_tag <= all_mode ? first_tag + 16'(slot) : cur.tag_id;
          out_data.avg_a0  <= miss ? '0 : quot[0];
          out_data.avg_a1  <= miss ? '0 : quot[1];
          out_data.avg_a2  <= miss ? '0 : quot[2];
          out_data.avg_a3  <= miss ? '0 : quot[3];
          out_data.last    <= !all_mode;
          if (all_mode) begin
            scan <= scan + 1'b1; state <= ST_SCAN;
          end else state <= ST_IDLE;
        end
        ST_TERM: if (!out_valid || out_ready) begin
          out_valid <= 1'b1;
          out_data  <= '{found: 1'b0, out_tag: '0, avg_a0: '0, avg_a1: '0,
                         avg_a2: '0, avg_a3: '0, last: 1'b1};
          state     <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/ptda_checker.sv @@
// Port-level checker for the per-tag distance averager, bound to the top level.
// Depends on ptda_pkg.
module ptda_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input ptda_pkg::out_beat_t out_data
);
  import ptda_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out beat dropped");
  a_term_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.last && !out_data.found |-> out_data.avg_a0 == '0 &&
    out_data.avg_a1 == '0 && out_data.avg_a2 == '0 && out_data.avg_a3 == '0)
    else $error("miss beat carries averages");
  a_reset_idle: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("out valid after reset");
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid) else $error("in beat withdrawn");
  a_out_known: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !$isunknown(out_data)) else $error("out beat has unknown bits");
endmodule

bind per_tag_distance_averager ptda_checker u_ptda_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
